// ===== rtl/core/dtwl_pkg.sv =====
// ----------------------------------------------------------------------------
// dtwl_pkg
// Shared types and constants for the tuning word serial loader.
// ----------------------------------------------------------------------------
package dtwl_pkg;

  // command codes on the input tuser
  localparam logic [1:0] CMD_FREQ  = 2'd0;
  localparam logic [1:0] CMD_PHASE = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // pulse kinds on the output tuser
  localparam logic [1:0] KIND_WCLK  = 2'd0;
  localparam logic [1:0] KIND_LATCH = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CLK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT = 2'd1;

  localparam logic [31:0] REF_CLK_RST = 32'd180000000;
  localparam logic [31:0] MAX_OUT_RST = 32'd72000000;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CTRL_W    = 8;
  localparam int unsigned FRAME_W   = WORD_W + CTRL_W;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned PHASE_W   = 16;
  localparam int unsigned PW_W      = 5;   // phase word bits, deg * 32 / 360
  localparam int unsigned CTRL_SH   = 3;
  localparam logic [31:0] PHASE_DIV = 32'd360;

  // one queued load: a reset pulse or a 40 bit frame
  typedef struct packed {
    logic               is_rst;
    logic [FRAME_W-1:0] frame;
  } entry_t;

endpackage

// ===== rtl/core/dtwl_front.sv =====
// ----------------------------------------------------------------------------
// dtwl_front
// Accepts commands, holds the registers and forms the load frame with a
// two bit per cycle restoring divider.
// ----------------------------------------------------------------------------
module dtwl_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dtwl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            in_vld_i,
  output logic                            in_rdy_o,
  input  logic [1:0]                      in_cmd_i,
  input  logic [31:0]                     in_freq_i,
  input  logic [dtwl_pkg::PHASE_W-1:0]    in_deg_i,
  output logic                            push_vld_o,
  input  logic                            push_rdy_i,
  output dtwl_pkg::entry_t                push_entry_o
);

  logic [31:0] ref_q, max_q;
  logic        busy_q, busy_d;
  logic        res_vld_q, res_vld_d;
  dtwl_pkg::entry_t res_q, res_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        phase_q, phase_d;
  logic        accept, push;
  logic [32:0] s1, s2;
  logic [31:0] fclamp;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                           input logic [31:0] dvs);
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;
    t    = {rem, nb};
    diff = t - {1'b0, dvs};
    ge   = (t >= {1'b0, dvs});
    return {ge, (ge ? diff[31:0] : t[31:0])};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= dtwl_pkg::REF_CLK_RST;
      max_q <= dtwl_pkg::MAX_OUT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dtwl_pkg::REG_REF_CLK) ref_q <= cfg_data_i;
      if (cfg_idx_i == dtwl_pkg::REG_MAX_OUT) max_q <= cfg_data_i;
    end
  end

  assign push     = res_vld_q && push_rdy_i;
  assign in_rdy_o = !busy_q && (!res_vld_q || push_rdy_i);
  assign accept   = in_vld_i && in_rdy_o;
  assign fclamp   = (in_freq_i > max_q) ? max_q : in_freq_i;

  assign s1 = div_step(rem_q, dvd_q[63], dvs_q);
  assign s2 = div_step(s1[31:0], dvd_q[62], dvs_q);

  always_comb begin
    busy_d    = busy_q;
    res_vld_d = res_vld_q;
    res_d     = res_q;
    dvd_d     = dvd_q;
    dvs_d     = dvs_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    if (push) res_vld_d = 1'b0;
    if (busy_q) begin
      dvd_d = {dvd_q[61:0], 2'b00};
      rem_d = s2[31:0];
      quo_d = {quo_q[29:0], s1[32], s2[32]};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d       = 1'b0;
        res_vld_d    = 1'b1;
        res_d.is_rst = 1'b0;
        if (phase_q) begin
          res_d.frame = {quo_d[dtwl_pkg::PW_W-1:0], {dtwl_pkg::CTRL_SH{1'b0}},
                         {dtwl_pkg::WORD_W{1'b0}}};
        end else begin
          res_d.frame = {{dtwl_pkg::CTRL_W{1'b0}}, quo_d};
        end
      end
    end else if (accept) begin
      rem_d = '0;
      cnt_d = '1;
      case (in_cmd_i)
        dtwl_pkg::CMD_FREQ: begin
          busy_d  = 1'b1;
          phase_d = 1'b0;
          dvd_d   = {fclamp, 32'd0};
          dvs_d   = ref_q;
        end
        dtwl_pkg::CMD_PHASE: begin
          busy_d  = 1'b1;
          phase_d = 1'b1;
          dvd_d   = {43'd0, in_deg_i, 5'd0};
          dvs_d   = dtwl_pkg::PHASE_DIV;
        end
        dtwl_pkg::CMD_RESET: begin
          res_vld_d    = 1'b1;
          res_d.is_rst = 1'b1;
          res_d.frame  = '0;
        end
        default: begin
          // unused command code is dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      res_vld_q <= 1'b0;
      cnt_q     <= '0;
      phase_q   <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      res_vld_q <= res_vld_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign push_vld_o   = res_vld_q;
  assign push_entry_o = res_q;

endmodule

// ===== rtl/core/dtwl_fifo.sv =====
// ----------------------------------------------------------------------------
// dtwl_fifo
// Short queue of formed loads between the front and the back.
// ----------------------------------------------------------------------------
module dtwl_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_vld_i,
  output logic             wr_rdy_o,
  input  dtwl_pkg::entry_t wr_entry_i,
  output logic             rd_vld_o,
  input  logic             rd_rdy_i,
  output dtwl_pkg::entry_t rd_entry_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dtwl_pkg::entry_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          wr, rd;

  assign wr_rdy_o   = (cnt_q != FULL_CNT);
  assign rd_vld_o   = (cnt_q != '0);
  assign wr         = wr_vld_i && wr_rdy_o;
  assign rd         = rd_vld_o && rd_rdy_i;
  assign rd_entry_o = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) cnt_d = cnt_q + CW'(1);
    if (rd && !wr) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + AW'(1);
      if (rd) rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_entry_i;
  end

endmodule

// ===== rtl/core/dtwl_back.sv =====
// ----------------------------------------------------------------------------
// dtwl_back
// Serializes a queued load into write clock pulses and a latch pulse, or
// sends a single reset pulse, through an output register.
// ----------------------------------------------------------------------------
module dtwl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_vld_i,
  output logic             pop_rdy_o,
  input  dtwl_pkg::entry_t pop_entry_i,
  output logic             out_vld_o,
  input  logic             out_rdy_i,
  output logic             out_bit_o,
  output logic [1:0]       out_kind_o,
  output logic             out_last_o
);

  logic                         act_q, act_d;
  logic                         rst_q, rst_d;
  logic [dtwl_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic [dtwl_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         ovld_q, ovld_d;
  logic                         obit_q, obit_d;
  logic [1:0]                   okind_q, okind_d;
  logic                         olast_q, olast_d;
  logic                         out_free, produce, ending, pop;

  localparam logic [dtwl_pkg::CNT_W-1:0] LAST_CNT = dtwl_pkg::CNT_W'(dtwl_pkg::FRAME_W);

  assign out_free  = !ovld_q || out_rdy_i;
  assign produce   = act_q && out_free;
  assign ending    = rst_q || (cnt_q == LAST_CNT);
  assign pop       = pop_vld_i && (!act_q || (produce && ending));
  assign pop_rdy_o = !act_q || (produce && ending);

  always_comb begin
    act_d   = act_q;
    rst_d   = rst_q;
    frame_d = frame_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q;
    obit_d  = obit_q;
    okind_d = okind_q;
    olast_d = olast_q;
    if (out_free) ovld_d = 1'b0;
    if (produce) begin
      ovld_d = 1'b1;
      if (rst_q) begin
        obit_d  = 1'b0;
        okind_d = dtwl_pkg::KIND_RESET;
        olast_d = 1'b1;
        act_d   = 1'b0;
      end else if (cnt_q == LAST_CNT) begin
        obit_d  = 1'b0;
        okind_d = dtwl_pkg::KIND_LATCH;
        olast_d = 1'b1;
        act_d   = 1'b0;
      end else begin
        obit_d  = frame_q[0];
        okind_d = dtwl_pkg::KIND_WCLK;
        olast_d = 1'b0;
        frame_d = {1'b0, frame_q[dtwl_pkg::FRAME_W-1:1]};
        cnt_d   = cnt_q + dtwl_pkg::CNT_W'(1);
      end
    end
    if (pop) begin
      act_d   = 1'b1;
      rst_d   = pop_entry_i.is_rst;
      frame_d = pop_entry_i.frame;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      rst_q  <= 1'b0;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      act_q  <= act_d;
      rst_q  <= rst_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    obit_q  <= obit_d;
    okind_q <= okind_d;
    olast_q <= olast_d;
  end

  assign out_vld_o  = ovld_q;
  assign out_bit_o  = obit_q;
  assign out_kind_o = okind_q;
  assign out_last_o = olast_q;

endmodule

// ===== rtl/core/dds_tuning_word_serial_loader.sv =====
// ----------------------------------------------------------------------------
// dds_tuning_word_serial_loader
// Turns frequency, phase and reset commands into synthesizer serial pulses.
// ----------------------------------------------------------------------------
// input stream: tuser carries the command, tdata the frequency and phase.
// output stream: one item per pulse; tdata bit 0 is the serial data level,
// tuser the pulse kind (write clock, update latch, reset), tlast marks the
// final pulse of a command. a load gives 40 write clock pulses, word lsb
// first then control byte, and one latch pulse; a reset command gives one
// reset pulse; command code 3 gives nothing.
// flow: a frequency or phase command passes through the front divider
// (two quotient bits a cycle) before its first pulse leaves. the back side
// sends one pulse a cycle while the receiver is ready. the queue lets the
// next division overlap the current shifting, so the sustained rate of loads
// is set by the serializer; reset commands skip the divider.
// reset clears the queue and all control state and loads the register
// defaults (180 MHz reference, 72 MHz clamp). when the receiver stalls the
// output register holds its pulse, the queue fills and then tready drops.
// ----------------------------------------------------------------------------
module dds_tuning_word_serial_loader #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dtwl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // freq_hz, phase_deg
  input  logic [1:0]                     s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // data_bit, zero fill
  output logic [1:0]                     m_axis_tuser,  // pulse_kind
  output logic                           m_axis_tlast
);

  logic             push_vld, push_rdy, pop_vld, pop_rdy, obit;
  dtwl_pkg::entry_t push_entry, pop_entry;

  dtwl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_vld_i     (s_axis_tvalid),
    .in_rdy_o     (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_freq_i    (s_axis_tdata[31:0]),
    .in_deg_i     (s_axis_tdata[47:32]),
    .push_vld_o   (push_vld),
    .push_rdy_i   (push_rdy),
    .push_entry_o (push_entry)
  );

  dtwl_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_vld_i   (push_vld),
    .wr_rdy_o   (push_rdy),
    .wr_entry_i (push_entry),
    .rd_vld_o   (pop_vld),
    .rd_rdy_i   (pop_rdy),
    .rd_entry_o (pop_entry)
  );

  dtwl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_vld_i   (pop_vld),
    .pop_rdy_o   (pop_rdy),
    .pop_entry_i (pop_entry),
    .out_vld_o   (m_axis_tvalid),
    .out_rdy_i   (m_axis_tready),
    .out_bit_o   (obit),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, obit};

endmodule

// ===== test/dds_tuning_word_serial_loader_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_tuning_word_serial_loader_chk
// Watches the config port and both streams, works out the pulse train each
// accepted request must produce and compares every output pulse against it.
// ----------------------------------------------------------------------------
module dds_tuning_word_serial_loader_chk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dtwl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // freq_hz, phase_deg
  input  logic [1:0]                     s_axis_tuser,  // command
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [7:0]                     m_axis_tdata,  // data_bit, zero fill
  input  logic [1:0]                     m_axis_tuser,  // pulse_kind
  input  logic                           m_axis_tlast,
  output int                             fail_cnt_o,
  output int                             pending_o
);

  typedef struct packed {
    logic       data_bit;
    logic [1:0] kind;
    logic       last;
  } pulse_t;

  pulse_t      pulse_q[$];
  logic [31:0] ref_clk_hz;
  logic [31:0] max_out_hz;
  int          pulse_cnt = 0;

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: pulse %0d: %s", $time, pulse_cnt, msg);
    fail_cnt_o++;
  endtask

  // clamp, then (f << 32) / ref keeping the low word; zero ref gives all ones
  function automatic logic [31:0] tuning_word(input logic [31:0] freq_hz);
    logic [31:0] f;
    logic [63:0] quo;
    f = (freq_hz > max_out_hz) ? max_out_hz : freq_hz;
    if (ref_clk_hz == 32'd0) return 32'hFFFF_FFFF;
    quo = {f, 32'd0} / {32'd0, ref_clk_hz};
    return quo[31:0];
  endfunction

  function automatic logic [7:0] phase_ctrl(input logic [15:0] deg);
    logic [31:0] steps;
    steps = ({16'd0, deg} * 32'd32) / 32'd360;
    return {steps[4:0], 3'b000};
  endfunction

  function automatic void queue_load(input logic [39:0] frame);
    for (int k = 0; k < 40; k++) begin
      pulse_q.push_back(pulse_t'{frame[k], dtwl_pkg::KIND_WCLK, 1'b0});
    end
    pulse_q.push_back(pulse_t'{1'b0, dtwl_pkg::KIND_LATCH, 1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pulse_t want;
    if (!rst_ni) begin
      ref_clk_hz = dtwl_pkg::REF_CLK_RST;
      max_out_hz = dtwl_pkg::MAX_OUT_RST;
      pulse_q.delete();
    end else begin
      // compare first: a request taken this cycle cannot own this pulse
      if (m_axis_tvalid && m_axis_tready) begin
        if (pulse_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pulse, kind %0d", m_axis_tuser));
        end else begin
          want = pulse_q.pop_front();
          if (m_axis_tdata !== {7'd0, want.data_bit})
            report_mismatch($sformatf("data %h, expected bit %0d",
                                      m_axis_tdata, want.data_bit));
          if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", m_axis_tuser, want.kind));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", m_axis_tlast, want.last));
        end
        pulse_cnt++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          dtwl_pkg::CMD_FREQ:  queue_load({8'h00, tuning_word(s_axis_tdata[31:0])});
          dtwl_pkg::CMD_PHASE: queue_load({phase_ctrl(s_axis_tdata[47:32]), 32'd0});
          dtwl_pkg::CMD_RESET:
            pulse_q.push_back(pulse_t'{1'b0, dtwl_pkg::KIND_RESET, 1'b1});
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dtwl_pkg::REG_REF_CLK: ref_clk_hz = cfg_data_i;
          dtwl_pkg::REG_MAX_OUT: max_out_hz = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = pulse_q.size();
  end

endmodule

// ===== test/dds_tuning_word_serial_loader_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_tuning_word_serial_loader_tb
// Drives frequency, phase, reset and unused commands through the loader
// under several register settings, with bursty requests and a stalling
// receiver; the checker beside the block predicts and compares every pulse.
// ----------------------------------------------------------------------------
module dds_tuning_word_serial_loader_tb;

  localparam logic [1:0]                     CMD_UNUSED   = 2'd3;
  localparam logic [dtwl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [dtwl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_AT       = 30;
  localparam int          HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [dtwl_pkg::CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [31:0]                    cfg_data_i    = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [47:0]                    s_axis_tdata  = '0;  // freq_hz, phase_deg
  logic [1:0]                     s_axis_tuser  = '0;  // command
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;        // data_bit, zero fill
  logic [1:0]                     m_axis_tuser;        // pulse_kind
  logic                           m_axis_tlast;

  int          fail_cnt;
  int          pending;
  int          n_sent     = 0;
  int          burst_left = 0;
  logic [31:0] cur_max    = dtwl_pkg::MAX_OUT_RST;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dds_tuning_word_serial_loader u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  dds_tuning_word_serial_loader_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  // receiver: one long hold once HOLD_AT requests have been sent, otherwise a rotating pattern
  int   rx_cyc    = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (!hold_done && n_sent >= HOLD_AT) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_cyc[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2: m_axis_tready <= (rx_cyc % 3 == 0);
        default: m_axis_tready <= ($urandom_range(0, 6) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned watch_cyc;
    watch_cyc = 0;
    while (watch_cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      watch_cyc++;
    end
    $display("dds_tuning_word_serial_loader_tb: FAIL");
    $finish;
  end

  task automatic write_reg(input logic [dtwl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == dtwl_pkg::REG_MAX_OUT) cur_max = value;
  endtask

  // requests go out in bursts; a gap only opens when a burst is used up
  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] freq_hz,
                          input logic [15:0] deg);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {deg, freq_hz};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    n_sent <= n_sent + 1;
  endtask

  // wait out every pending pulse, then a settle period of SETTLE_CYCLES
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1000);
      1: return cur_max - 32'd2 + 32'($urandom_range(0, 4));
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, cur_max);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_deg();
    int k;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 720));
      2: begin
        // land on either side of a phase step
        k = $urandom_range(1, 64);
        return 16'((k * 45 + 3) / 4 - $urandom_range(0, 1));
      end
      default: return 16'hFFFF - 16'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic send_random(input int n);
    int          done;
    int          pick;
    logic [1:0]  cmd;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      cmd  = (pick < 45) ? dtwl_pkg::CMD_FREQ :
             (pick < 80) ? dtwl_pkg::CMD_PHASE :
             (pick < 92) ? dtwl_pkg::CMD_RESET : CMD_UNUSED;
      send_cmd(cmd, pick_freq(), pick_deg());
      if (cmd != CMD_UNUSED) done++;
    end
  endtask

  initial begin
    logic [31:0] ref_hz;
    logic [31:0] max_hz;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: clamp edges and phase step edges
    send_cmd(dtwl_pkg::CMD_FREQ, 32'd0, 16'd0);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'd1, 16'd0);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'd72_000_000, 16'd0);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'd72_000_001, 16'd0);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'hAAAA_5555, 16'hFFFF);
    send_cmd(dtwl_pkg::CMD_PHASE, 32'hFFFF_FFFF, 16'd0);
    send_cmd(dtwl_pkg::CMD_PHASE, 32'd0, 16'd11);
    send_cmd(dtwl_pkg::CMD_PHASE, 32'd0, 16'd12);
    send_cmd(dtwl_pkg::CMD_PHASE, 32'd0, 16'd359);
    send_cmd(dtwl_pkg::CMD_PHASE, 32'd0, 16'd360);
    send_cmd(dtwl_pkg::CMD_PHASE, 32'd0, 16'd361);
    send_cmd(dtwl_pkg::CMD_PHASE, 32'd0, 16'hFFFF);
    send_cmd(dtwl_pkg::CMD_RESET, 32'd0, 16'd0);
    send_cmd(CMD_UNUSED, 32'h1234_5678, 16'd90);
    send_cmd(dtwl_pkg::CMD_RESET, 32'hFFFF_FFFF, 16'hFFFF);
    send_random(100);
    wait_idle();

    // unit reference: quotient overflows the word
    write_reg(dtwl_pkg::REG_REF_CLK, 32'd1);
    write_reg(dtwl_pkg::REG_MAX_OUT, 32'hFFFF_FFFF);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'hFFFF_FFFF, 16'd0);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'h8000_0001, 16'd0);
    send_random(50);
    wait_idle();

    // zero reference
    write_reg(dtwl_pkg::REG_REF_CLK, 32'd0);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'd0, 16'd0);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'd12345, 16'd0);
    send_random(30);
    wait_idle();

    // widest reference, clamp at zero; spare indexes must be ignored
    write_reg(dtwl_pkg::REG_REF_CLK, 32'hFFFF_FFFF);
    write_reg(dtwl_pkg::REG_MAX_OUT, 32'd0);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h5A5A_A5A5);
    send_cmd(dtwl_pkg::CMD_FREQ, 32'hFFFF_FFFF, 16'd0);
    send_random(30);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 3))
        0: ref_hz = $urandom_range(1, 1000);
        1: ref_hz = $urandom;
        2: ref_hz = $urandom_range(100_000_000, 200_000_000);
        default: ref_hz = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 2))
        0: max_hz = $urandom;
        1: max_hz = 32'hFFFF_FFFF;
        default: max_hz = $urandom_range(0, 100_000_000);
      endcase
      write_reg(dtwl_pkg::REG_REF_CLK, ref_hz);
      write_reg(dtwl_pkg::REG_MAX_OUT, max_hz);
      write_reg((p % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      send_random(40);
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("dds_tuning_word_serial_loader_tb: PASS");
    end else begin
      $display("dds_tuning_word_serial_loader_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== dds_tuning_word_serial_loader.f =====
rtl/core/dtwl_pkg.sv
rtl/core/dtwl_front.sv
rtl/core/dtwl_fifo.sv
rtl/core/dtwl_back.sv
rtl/core/dds_tuning_word_serial_loader.sv
test/dds_tuning_word_serial_loader_chk.sv
test/dds_tuning_word_serial_loader_tb.sv
